// ===== rtl/ranked_sorted_set_table_top_macros.svh =====
// Assertion macros for the ranked sorted set table
`ifndef RANKED_SORTED_SET_TABLE_TOP_MACROS_SVH
`define RANKED_SORTED_SET_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RSST_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RSST_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RSST_ASSERT_IMP(label, clk, rst_n, a, c)
`define RSST_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/rsst_pkg.sv =====
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared types and constants of the ranked sorted set table.
// ----------------------------------------------------------------------------
`default_nettype none
package rsst_pkg;
    localparam int CapacityDef = 256;
    localparam int KeyW = 64;
    localparam int RankW = 9;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_RANK_OF = 2'd2,
        CMD_AT_RANK = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_LOOK = 2'd1,
        BK_APPLY = 2'd2,
        BK_OUT = 2'd3
    } bk_state_t;

    // one queued command word
    typedef struct packed {
        cmd_t cmd;
        logic [KeyW-1:0] score;
        logic [KeyW-1:0] id;
        logic [RankW-1:0] want;
    } cmd_word_t;
endpackage
`default_nettype wire

// ===== rtl/ranked_sorted_set_table_top.sv =====
// Ranked sorted set table.
// Input channel: in_valid/in_stall with command, key_score, key_id,
// wanted_rank. Output channel: out_valid/out_stall with status, found_rank,
// entry_score, entry_id, entry_count. One result word per command.
// Entries live in a shifting cell array that compares all cells with the key
// at once; the end of the run of held cells below the key gives the position.
// The back end takes each command through load, compare, apply shift and
// present (states BK_IDLE, BK_LOOK, BK_APPLY, BK_OUT); the result word is
// registered in BK_APPLY and shown in BK_OUT. The back-end sequencer takes
// no new command word until the result is taken. A two-word queue in front
// lets the sender keep going while a result waits. When the receiver
// stalls, the result is held and the queue fills, then in_stall rises.
// Reset empties the table and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ranked_sorted_set_table_top
// Top level: front queue plus back-end executor.
// ----------------------------------------------------------------------------
`default_nettype none
module ranked_sorted_set_table_top
    import rsst_pkg::*;
#(
    parameter int CAPACITY = CapacityDef
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic [1:0] command,
    input  wire logic signed [KeyW-1:0] key_score,
    input  wire logic signed [KeyW-1:0] key_id,
    input  wire logic [RankW-1:0] wanted_rank,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [1:0] status,
    output logic [RankW-1:0] found_rank,
    output logic signed [KeyW-1:0] entry_score,
    output logic signed [KeyW-1:0] entry_id,
    output logic [RankW-1:0] entry_count
);
    localparam int CntW = $clog2(CAPACITY + 1);
    cmd_word_t in_word, q_word;
    logic q_valid, q_pop;

    assign in_word = '{cmd: cmd_t'(command), score: key_score, id: key_id,
        want: wanted_rank};

    rsst_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
    );

    rsst_back #(.CAPACITY(CAPACITY), .CntW(CntW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
        .q_word(q_word), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .found_rank(found_rank), .entry_score(entry_score),
        .entry_id(entry_id), .entry_count(entry_count)
    );
endmodule
`default_nettype wire

// ===== rtl/rsst_front.sv =====
// ----------------------------------------------------------------------------
// rsst_front
// Accepts command words and queues them in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rsst_front
    import rsst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire cmd_word_t in_word,
    output logic q_valid,
    input  wire logic q_pop,
    output cmd_word_t q_word
);
    cmd_word_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word = mem_reg[rd_ptr_reg];

    // store incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rsst_array.sv =====
// ----------------------------------------------------------------------------
// rsst_array
// Shifting cell array: every cell compares with the key in parallel, and
// insert or delete moves the tail of the array by one place.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ranked_sorted_set_table_top_macros.svh"
module rsst_array
    import rsst_pkg::*;
#(
    parameter int CAPACITY = CapacityDef,
    parameter int CntW = $clog2(CAPACITY + 1)
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [KeyW-1:0] key_score,
    input  wire logic [KeyW-1:0] key_id,
    input  wire logic do_insert,
    input  wire logic do_delete,
    input  wire logic [CntW-1:0] pos,
    output logic [CAPACITY-1:0] less_vec,
    output logic [CAPACITY-1:0] eq_vec,
    input  wire logic [CntW-1:0] rd_idx,
    output logic [KeyW-1:0] rd_score,
    output logic [KeyW-1:0] rd_id
);
    localparam int IdxW = $clog2(CAPACITY);
    logic [KeyW-1:0] sc_reg [CAPACITY];
    logic [KeyW-1:0] id_reg [CAPACITY];

    // compare every cell with the key (signed score, then signed id)
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            less_vec[k] = ($signed(sc_reg[k]) < $signed(key_score)) ||
                ((sc_reg[k] == key_score) && ($signed(id_reg[k]) < $signed(key_id)));
            eq_vec[k] = (sc_reg[k] == key_score) && (id_reg[k] == key_id);
        end
    end

    // shift cells for insert or delete
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (do_insert)
            begin
                if (CntW'(k) == pos)
                begin
                    sc_reg[k] <= key_score;
                    id_reg[k] <= key_id;
                end
                else if (CntW'(k) > pos && k > 0)
                begin
                    sc_reg[k] <= sc_reg[(k > 0) ? k - 1 : 0];
                    id_reg[k] <= id_reg[(k > 0) ? k - 1 : 0];
                end
            end
            else if (do_delete && CntW'(k) >= pos && k < CAPACITY - 1)
            begin
                sc_reg[k] <= sc_reg[(k < CAPACITY - 1) ? k + 1 : k];
                id_reg[k] <= id_reg[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    // registered read of one cell
    always_ff @(posedge clk)
    begin
        rd_score <= sc_reg[rd_idx[IdxW-1:0]];
        rd_id <= id_reg[rd_idx[IdxW-1:0]];
    end

    `RSST_ASSERT_IMP(a_no_dual_op, clk, rst_n, do_insert, !do_delete)
    `RSST_ASSERT_NEXT(a_ins_lands, clk, rst_n, do_insert && pos == '0,
        sc_reg[0] == $past(key_score) && id_reg[0] == $past(key_id))
    `RSST_ASSERT_IMP(a_pos_range, clk, rst_n, do_insert || do_delete,
        pos < CntW'(CAPACITY))
endmodule
`default_nettype wire

// ===== rtl/rsst_back.sv =====
// ----------------------------------------------------------------------------
// rsst_back
// Executes queued commands on the cell array and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ranked_sorted_set_table_top_macros.svh"
module rsst_back
    import rsst_pkg::*;
#(
    parameter int CAPACITY = CapacityDef,
    parameter int CntW = $clog2(CAPACITY + 1)
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    output logic q_pop,
    input  wire cmd_word_t q_word,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [1:0] status,
    output logic [RankW-1:0] found_rank,
    output logic [KeyW-1:0] entry_score,
    output logic [KeyW-1:0] entry_id,
    output logic [RankW-1:0] entry_count
);
    bk_state_t state_reg, state_next;
    cmd_word_t cw_reg;
    logic [CntW-1:0] cnt_reg, pos_reg, pos_calc;
    logic hit_reg;
    logic [CAPACITY-1:0] less_vec, eq_vec, valid_vec;
    logic [CAPACITY:0] run_vec;
    logic do_insert, do_delete, load, ok_at;
    logic [CntW-1:0] rd_idx;
    logic [KeyW-1:0] rd_score, rd_id;
    logic [1:0] st_reg;
    logic [RankW-1:0] rank_reg;

    rsst_array #(.CAPACITY(CAPACITY), .CntW(CntW)) u_array (
        .clk(clk), .rst_n(rst_n),
        .key_score(cw_reg.score), .key_id(cw_reg.id),
        .do_insert(do_insert), .do_delete(do_delete), .pos(pos_reg),
        .less_vec(less_vec), .eq_vec(eq_vec),
        .rd_idx(rd_idx), .rd_score(rd_score), .rd_id(rd_id)
    );

    // held cells below the key form a run from cell 0; its end gives the position
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            valid_vec[k] = (CntW'(k) < cnt_reg);
        end
        run_vec = {1'b0, less_vec & valid_vec};
        pos_calc = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (run_vec[k] && !run_vec[k + 1])
            begin
                pos_calc = pos_calc | CntW'(k + 1);
            end
        end
    end

    assign ok_at = (cw_reg.want != '0) &&
        ({{CntW{1'b0}}, cw_reg.want} <= {{RankW{1'b0}}, cnt_reg});
    assign rd_idx = CntW'(cw_reg.want) - CntW'(1);

    // next state
    always_comb
    begin
        case (state_reg)
            BK_IDLE: state_next = q_valid ? BK_LOOK : BK_IDLE;
            BK_LOOK: state_next = BK_APPLY;
            BK_APPLY: state_next = BK_OUT;
            BK_OUT: state_next = out_stall ? BK_OUT : BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        load = (state_reg == BK_IDLE) && q_valid;
        q_pop = load;
        out_valid = (state_reg == BK_OUT);
        do_insert = (state_reg == BK_APPLY) && (cw_reg.cmd == CMD_INSERT) &&
            (cnt_reg < CntW'(CAPACITY));
        do_delete = (state_reg == BK_APPLY) && (cw_reg.cmd == CMD_DELETE) && hit_reg;
    end

    // hold command, position and result fields
    always_ff @(posedge clk)
    begin
        if (load) cw_reg <= q_word;
        if (state_reg == BK_LOOK)
        begin
            pos_reg <= pos_calc;
            hit_reg <= (pos_calc < cnt_reg) && (|(eq_vec & valid_vec & ~less_vec));
        end
        if (state_reg == BK_APPLY)
        begin
            entry_score <= '0;
            entry_id <= '0;
            st_reg <= ST_NOT_FOUND;
            rank_reg <= '0;
            case (cw_reg.cmd)
                CMD_INSERT:
                begin
                    if (cnt_reg >= CntW'(CAPACITY))
                    begin
                        st_reg <= ST_FULL;
                    end
                    else
                    begin
                        st_reg <= ST_DONE;
                        rank_reg <= RankW'(pos_reg + CntW'(1));
                    end
                end
                CMD_DELETE, CMD_RANK_OF:
                begin
                    if (hit_reg)
                    begin
                        st_reg <= ST_DONE;
                        rank_reg <= RankW'(pos_reg + CntW'(1));
                    end
                end
                CMD_AT_RANK:
                begin
                    if (ok_at)
                    begin
                        st_reg <= ST_DONE;
                        rank_reg <= cw_reg.want;
                        entry_score <= rd_score;
                        entry_id <= rd_id;
                    end
                end
                default: st_reg <= ST_NOT_FOUND;
            endcase
        end
    end

    assign status = st_reg;
    assign found_rank = rank_reg;
    assign entry_count = RankW'(cnt_reg);

    // sequencer state and held count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_insert) cnt_reg <= cnt_reg + CntW'(1);
            else if (do_delete) cnt_reg <= cnt_reg - CntW'(1);
        end
    end

    `RSST_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= CntW'(CAPACITY))
    `RSST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `RSST_ASSERT_IMP(a_pop_idle, clk, rst_n, q_pop, state_reg == BK_IDLE)
endmodule
`default_nettype wire
